// ===== rtl/core/iptl_pkg.sv =====
// Package for the IPv4 binary trie lookup unit: item structs, command and
// status codes, lookup state encoding and fixed field widths.
// No dependencies; used by every file in rtl/core.
package iptl_pkg;

	// Fixed field widths.
	localparam int PTR_W       = 24;
	localparam int NODE_IDX_W  = 16;
	localparam int IPV4_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int BIT_IDX_W   = 5;
	localparam int REC_W       = 2 * PTR_W;

	// Top address bit, walked first.
	localparam logic [BIT_IDX_W-1:0] ADDR_TOP_BIT = 5'd31;

	// Reset value of the leaf base register.
	localparam logic [PTR_W-1:0] LEAF_BASE_RESET = 24'hFFFF00;

	// Command codes.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Lookup status codes.
	localparam logic [STATUS_W-1:0] STATUS_FOUND        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

	// Lookup controller states.
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// One input item.
	typedef struct packed {
		logic                  command;
		logic [NODE_IDX_W-1:0] node_index;
		logic [PTR_W-1:0]      zero_branch;
		logic [PTR_W-1:0]      one_branch;
		logic [IPV4_W-1:0]     ipv4_address;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [PTR_W-1:0]    country_index;
		logic [STATUS_W-1:0] lookup_status;
	} out_item_t;

endpackage

// ===== rtl/core/iptl_node_mem.sv =====
// Node record memory for the trie lookup: one write port, one read port,
// read data registered. Depends on iptl_pkg.
module iptl_node_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [iptl_pkg::REC_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [iptl_pkg::REC_W-1:0] rdata
);
	import iptl_pkg::*;

	logic [REC_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/ipv4_binary_trie_country_lookup_unit.sv =====
// Top level of the IPv4 binary trie lookup unit: command handshake, lookup
// controller and leaf base register. Depends on iptl_pkg and iptl_node_mem.
//
// Channel   Ports                              Direction  Accepted when
// request   start, busy, request               in         start && !busy
// result    done, result                       out        done (one cycle)
// config    leaf_base_we, leaf_base_wdata      in         leaf_base_we
//
// A write item stores its record at the accepting edge if its index is below
// NODE_COUNT and gives no result; the next item can follow in the next cycle.
// A lookup reads node 0 at the accepting edge, then visits 1 to 32 nodes, one
// per address bit, each walk cycle taking the read data of the single
// node memory port and issuing the next read. done rises the cycle after
// the last walk cycle.
// busy is high during the walk. Reset returns the controller to idle and loads
// the leaf base with its reset value; node records are undefined until
// written. The receiver cannot stall.
module ipv4_binary_trie_country_lookup_unit #(
	parameter int NODE_COUNT = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  iptl_pkg::in_item_t          request,
	output logic                        done,
	output iptl_pkg::out_item_t         result,
	input  logic                        leaf_base_we,
	input  logic [iptl_pkg::PTR_W-1:0]  leaf_base_wdata
);
	import iptl_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [PTR_W:0] NODE_LIMIT = (PTR_W+1)'(NODE_COUNT);

	state_t               state_q, next_state;
	logic [BIT_IDX_W-1:0] bit_q;
	logic [IPV4_W-1:0]    addr_q;
	logic [PTR_W-1:0]     leaf_base_q;
	logic                 done_q;
	out_item_t            result_q;

	logic             accept, lookup_accept, write_accept;
	logic [PTR_W:0]   wr_idx_ext;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [REC_W-1:0] mem_rdata;
	logic [PTR_W-1:0] ptr;
	logic             is_leaf, last_bit, ptr_oor, finish;
	out_item_t        finish_item;

	// Request decode.
	assign accept        = start && !busy;
	assign wr_idx_ext    = (PTR_W+1)'(request.node_index);
	assign lookup_accept = accept && (request.command == CMD_LOOKUP);
	assign write_accept  = accept && (request.command == CMD_WRITE) &&
	                       (wr_idx_ext < NODE_LIMIT);

	// Branch selection from the node just read.
	assign ptr      = addr_q[bit_q] ? mem_rdata[REC_W-1:PTR_W] : mem_rdata[PTR_W-1:0];
	assign is_leaf  = ptr >= leaf_base_q;
	assign last_bit = bit_q == '0;
	assign ptr_oor  = {1'b0, ptr} >= NODE_LIMIT;

	iptl_node_mem #(
		.DEPTH (NODE_COUNT),
		.AW    (AW)
	) u_node_mem (
		.clk   (clk),
		.we    (write_accept),
		.waddr (wr_idx_ext[AW-1:0]),
		.wdata ({request.one_branch, request.zero_branch}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_IDLE: begin
				if (lookup_accept) begin
					next_state = ST_WALK;
				end
			end
			ST_WALK: begin
				if (is_leaf || last_bit || ptr_oor) begin
					next_state = ST_IDLE;
				end
			end
			default: next_state = ST_IDLE;
		endcase
	end

	// Controller outputs: memory read request and the finishing result.
	always_comb begin
		busy        = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		finish      = 1'b0;
		finish_item = '{country_index: '0, lookup_status: STATUS_EXHAUSTED};
		case (state_q)
			ST_IDLE: begin
				mem_re = lookup_accept;
			end
			ST_WALK: begin
				busy = 1'b1;
				if (is_leaf) begin
					finish      = 1'b1;
					finish_item = '{country_index: ptr - leaf_base_q,
					                lookup_status: STATUS_FOUND};
				end else if (last_bit) begin
					finish = 1'b1;
				end else if (ptr_oor) begin
					finish      = 1'b1;
					finish_item = '{country_index: '0,
					                lookup_status: STATUS_OUT_OF_RANGE};
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr[AW-1:0];
				end
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			leaf_base_q <= LEAF_BASE_RESET;
		end else begin
			state_q <= next_state;
			done_q  <= finish;
			if (leaf_base_we) begin
				leaf_base_q <= leaf_base_wdata;
			end
		end
	end

	// Walk position and result payload.
	always_ff @(posedge clk) begin
		if (lookup_accept) begin
			addr_q <= request.ipv4_address;
			bit_q  <= ADDR_TOP_BIT;
		end else if (mem_re) begin
			bit_q <= bit_q - 1'b1;
		end
		if (finish) begin
			result_q <= finish_item;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result only follows a walk cycle.
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_WALK))
		else $error("result strobe without a preceding walk cycle");

	// The node memory is never written during a walk.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		write_accept |-> state_q == ST_IDLE)
		else $error("node write during a lookup walk");

	// A failed lookup always reports index zero.
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.lookup_status != STATUS_FOUND) |-> result.country_index == '0)
		else $error("nonzero country index on a failed lookup");

	// An accepted lookup keeps the unit busy in the next cycle.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lookup_accept |=> busy)
		else $error("lookup accepted but walk not started");

	// A walk never continues past the last address bit.
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && last_bit) |=> state_q == ST_IDLE)
		else $error("walk continued past address bit zero");

endmodule

// ===== tb/trie_lookup_checker.sv =====
// Checker for the IPv4 binary trie lookup unit: watches the request, result
// and leaf base channels, predicts every lookup and compares each result.
// Depends on iptl_pkg for the item structs and the command and status codes.
module trie_lookup_checker #(
	parameter int NODE_COUNT = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  iptl_pkg::in_item_t         request,
	input  logic                       done,
	input  iptl_pkg::out_item_t        result,
	input  logic                       leaf_base_we,
	input  logic [iptl_pkg::PTR_W-1:0] leaf_base_wdata,
	output int                         mismatches,
	output int                         expected_left,
	output int                         found_count,
	output int                         exhausted_count,
	output int                         range_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import iptl_pkg::*;

	// Shadow copy of the node records and of the leaf threshold.
	logic [REC_W-1:0] trie_rec [NODE_COUNT];
	logic [PTR_W-1:0] leaf_base = LEAF_BASE_RESET;

	// Lookup results still owed by the block, oldest first.
	out_item_t country_pending [$];

	int bad_count = 0;
	int left_q    = 0;
	int found_q   = 0;
	int exhaust_q = 0;
	int range_q   = 0;

	assign mismatches      = bad_count;
	assign expected_left   = left_q;
	assign found_count     = found_q;
	assign exhausted_count = exhaust_q;
	assign range_count     = range_q;

	// Walk the shadow trie from node 0, one address bit per level.
	function automatic out_item_t walk_trie(input logic [IPV4_W-1:0] addr);
		out_item_t        res;
		logic [REC_W-1:0] rec;
		logic [PTR_W-1:0] ptr;
		int unsigned      node;
		bit               settled;
		res.country_index = '0;
		res.lookup_status = STATUS_EXHAUSTED;
		node = 0;
		settled = 1'b0;
		for (int b = int'(ADDR_TOP_BIT); b >= 0 && !settled; b--) begin
			if (node >= NODE_COUNT) begin
				// The next node lies past the memory.
				res.lookup_status = STATUS_OUT_OF_RANGE;
				settled = 1'b1;
			end else begin
				rec = trie_rec[node];
				ptr = addr[b] ? rec[REC_W-1:PTR_W] : rec[PTR_W-1:0];
				if (ptr >= leaf_base) begin
					res.country_index = ptr - leaf_base;
					res.lookup_status = STATUS_FOUND;
					settled = 1'b1;
				end else begin
					node = 32'(ptr);
				end
			end
		end
		return res;
	endfunction

	// Compare results first, then take in the item of this edge, then the register
	// write, which is not seen by the prediction for a lookup taken at that edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			leaf_base = LEAF_BASE_RESET;
			country_pending.delete();
			left_q <= 0;
		end else begin
			if (done) begin
				if (country_pending.size() == 0) begin
					errs++;
					$display("%0t: expected no result, actual index %h status %0d",
						$time, result.country_index, result.lookup_status);
				end else begin
					want = country_pending.pop_front();
					if (result.country_index !== want.country_index) begin
						errs++;
						$display("%0t: country_index expected %h actual %h",
							$time, want.country_index, result.country_index);
					end
					if (result.lookup_status !== want.lookup_status) begin
						errs++;
						$display("%0t: lookup_status expected %0d actual %0d",
							$time, want.lookup_status, result.lookup_status);
					end
					case (want.lookup_status)
						STATUS_FOUND:     found_q <= found_q + 1;
						STATUS_EXHAUSTED: exhaust_q <= exhaust_q + 1;
						default:          range_q <= range_q + 1;
					endcase
				end
			end
			if (start && !busy) begin
				if (request.command == CMD_WRITE) begin
					if (int'(request.node_index) < NODE_COUNT) begin
						trie_rec[request.node_index] = {request.one_branch, request.zero_branch};
					end
				end else begin
					country_pending.push_back(walk_trie(request.ipv4_address));
				end
			end
			if (leaf_base_we) begin
				leaf_base = leaf_base_wdata;
			end
			bad_count <= bad_count + errs;
			left_q <= country_pending.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the lookup unit testbench: clock, reset, trie building and lookup
// stimulus, leaf base phases and the final verdict.
// Depends on iptl_pkg, the lookup unit and trie_lookup_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import iptl_pkg::*;

	localparam int NODE_COUNT = 65536;
	localparam int DRAIN = 40;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	in_item_t         request = '0;
	logic             done;
	out_item_t        result;
	logic             leaf_base_we = 1'b0;
	logic [PTR_W-1:0] leaf_base_wdata = '0;

	int mismatches;
	int expected_left;
	int found_count;
	int exhausted_count;
	int range_count;

	// Stimulus side view: current threshold and the nodes that are safe to
	// reach in this phase, i.e. written with pointers to safe nodes only.
	logic [PTR_W-1:0] begin_now = LEAF_BASE_RESET;
	bit               is_live [NODE_COUNT];
	int               live_nodes [$];
	int               burst_left = 0;
	int               writes_sent = 0;
	int               lookups_sent = 0;
	int               phases_run = 1;

	ipv4_binary_trie_country_lookup_unit #(
		.NODE_COUNT(NODE_COUNT)
	) uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.request            (request),
		.done               (done),
		.result             (result),
		.leaf_base_we       (leaf_base_we),
		.leaf_base_wdata    (leaf_base_wdata)
	);

	trie_lookup_checker #(
		.NODE_COUNT(NODE_COUNT)
	) u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.request            (request),
		.done               (done),
		.result             (result),
		.leaf_base_we       (leaf_base_we),
		.leaf_base_wdata    (leaf_base_wdata),
		.mismatches         (mismatches),
		.expected_left      (expected_left),
		.found_count        (found_count),
		.exhausted_count    (exhausted_count),
		.range_count        (range_count)
	);

	always #4 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#(10_000_000);
		$display("testbench: FAIL");
		$finish;
	end

	// Mostly short gaps, a few long ones, and now and then a burst with none.
	function automatic int idle_cycles();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 3) begin
			burst_left = $urandom_range(40, 10);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// A leaf pointer for the current threshold, sometimes at either end.
	function automatic logic [PTR_W-1:0] leaf_pointer();
		int r;
		r = $urandom_range(7, 0);
		if (r == 0) return begin_now;
		if (r == 1) return '1;
		return PTR_W'($urandom_range(24'hFFFFFF, begin_now));
	endfunction

	// A branch pointer that never leads to a node left unwritten in this phase.
	function automatic logic [PTR_W-1:0] pick_pointer(input int node_pct);
		int               r;
		logic [PTR_W-1:0] p;
		r = $urandom_range(99, 0);
		if (r < node_pct && live_nodes.size() > 0) begin
			return PTR_W'(live_nodes[$urandom_range(live_nodes.size() - 1, 0)]);
		end
		if (r < node_pct + 15 && begin_now > NODE_COUNT) begin
			// Points past the node memory.
			if (r % 4 == 0) return PTR_W'(NODE_COUNT);
			if (r % 4 == 1) return begin_now - 1;
			return PTR_W'($urandom_range(begin_now - 1, NODE_COUNT));
		end
		if (r >= 95) begin
			p = PTR_W'($urandom());
			if (p < begin_now && p < NODE_COUNT && !is_live[p]) return leaf_pointer();
			return p;
		end
		return leaf_pointer();
	endfunction

	function automatic void mark_live(input int idx);
		if (!is_live[idx]) begin
			is_live[idx] = 1'b1;
			live_nodes.push_back(idx);
		end
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_item(input in_item_t it);
		int gap;
		start <= 1'b1;
		request <= it;
		do @(posedge clk); while (busy);
		gap = idle_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_node(input int idx, input logic [PTR_W-1:0] zb,
		input logic [PTR_W-1:0] ob);
		in_item_t it;
		mark_live(idx);
		it.command = CMD_WRITE;
		it.node_index = idx[NODE_IDX_W-1:0];
		it.zero_branch = zb;
		it.one_branch = ob;
		it.ipv4_address = $urandom();
		send_item(it);
		writes_sent++;
	endtask

	// The node is marked first so that it may point at itself.
	task automatic store_node(input int idx, input int node_pct);
		logic [PTR_W-1:0] zb;
		logic [PTR_W-1:0] ob;
		mark_live(idx);
		zb = pick_pointer(node_pct);
		ob = pick_pointer(node_pct);
		write_node(idx, zb, ob);
	endtask

	task automatic look_up(input logic [IPV4_W-1:0] addr);
		in_item_t it;
		it.command = CMD_LOOKUP;
		it.node_index = NODE_IDX_W'($urandom());
		it.zero_branch = PTR_W'($urandom());
		it.one_branch = PTR_W'($urandom());
		it.ipv4_address = addr;
		send_item(it);
		lookups_sent++;
	endtask

	// Hold the sender off until every owed result has come.
	task automatic wait_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
	endtask

	task automatic settle();
		wait_results();
		repeat (DRAIN) @(posedge clk);
	endtask

	// New threshold while idle; the old trie no longer counts as safe.
	task automatic set_begin(input logic [PTR_W-1:0] v);
		settle();
		leaf_base_we <= 1'b1;
		leaf_base_wdata <= v;
		@(posedge clk);
		leaf_base_we <= 1'b0;
		begin_now = v;
		foreach (is_live[i]) is_live[i] = 1'b0;
		live_nodes.delete();
		phases_run++;
	endtask

	// Inner nodes first, root last, so the root can reach all of them.
	task automatic build_trie();
		int n;
		n = $urandom_range(16, 6);
		repeat (n) begin
			if ($urandom_range(9, 0) < 7) store_node($urandom_range(31, 1), 70);
			else store_node($urandom_range(65535, 1), 70);
		end
		store_node(0, 80);
	endtask

	// Mostly lookups, with node rewrites that keep the trie safe.
	task automatic random_items(input int count);
		int               r;
		int               idx;
		logic [IPV4_W-1:0] addr;
		repeat (count) begin
			r = $urandom_range(99, 0);
			if (r < 1) begin
				wait_results();
			end else if (r < 25) begin
				idx = $urandom_range(9, 0);
				if (idx < 5) idx = live_nodes[$urandom_range(live_nodes.size() - 1, 0)];
				else if (idx < 8) idx = $urandom_range(63, 0);
				else idx = $urandom_range(65535, 0);
				// A few rewrites point only at nodes, which builds long walks.
				store_node(idx, (r < 5) ? 100 : 60);
			end else begin
				addr = $urandom();
				if (r < 40) addr = addr & $urandom() & $urandom();
				else if (r < 55) addr = addr | $urandom() | $urandom();
				look_up(addr);
			end
		end
	endtask

	initial begin
		logic [PTR_W-1:0] plan [7];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset threshold: self loop, pointer past memory on the first and
		// on the last bit, leaves at both ends, and a full-depth walk.
		write_node(0, 24'h000000, 24'h010000);
		look_up(32'h00000000);
		look_up(32'h00000001);
		look_up(32'h80000000);
		write_node(16'hFFFF, 24'hFFFFFF, 24'hFFFF00);
		write_node(0, 24'h00FFFF, 24'hFFFEFF);
		look_up(32'h00000000);
		look_up(32'h40000000);
		look_up(32'hFFFFFFFF);
		write_node(1, 24'h000001, 24'hFFFF7F);
		write_node(0, 24'h000001, 24'h00FFFF);
		look_up(32'h00000000);
		look_up(32'h00000001);
		look_up(32'h7FFFFFFF);
		look_up(32'hBFFFFFFF);
		random_items(250);

		// Remaining thresholds: both extremes, zero, the memory boundary and
		// two random ones on either side of it.
		plan = '{24'h000001, 24'hFFFFFF, 24'h000000, 24'h010000, 24'h010001,
			24'h000000, 24'h000000};
		plan[5] = PTR_W'($urandom_range(24'h00FFFF, 2));
		plan[6] = PTR_W'($urandom_range(24'hFFFFFE, 24'h010002));
		foreach (plan[i]) begin
			set_begin(plan[i]);
			build_trie();
			random_items(250);
		end
		settle();

		$display("Run summary: %0d node writes and %0d lookups over %0d leaf thresholds.",
			writes_sent, lookups_sent, phases_run);
		$display("Lookups checked: %0d found, %0d bits exhausted, %0d past node memory.",
			found_count, exhausted_count, range_count);
		if (mismatches == 0 && expected_left == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/iptl_pkg.sv
rtl/core/iptl_node_mem.sv
rtl/core/ipv4_binary_trie_country_lookup_unit.sv
tb/trie_lookup_checker.sv
tb/testbench.sv
